### hw/rtl/wsf_pkg.sv
package wsf_pkg;

    // Default sensor-set limit
    localparam int DEF_MAX_SENSORS = 64;

    // Field widths
    localparam int VALUE_W  = 16;
    localparam int SCORE_W  = 16;
    localparam int STATUS_W = 2;

    // Signed value times unsigned score (score zero-extended to 17 bits)
    localparam int PROD_W = VALUE_W + SCORE_W + 1;

    // Quotient magnitude never exceeds 32768, so 17 quotient bits suffice
    localparam int QUO_W  = VALUE_W + 1;
    localparam int DCNT_W = $clog2(QUO_W);
    localparam logic [QUO_W-1:0] QUO_LIM = QUO_W'(32768);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_VALID = 2'd1,
        ST_ZERO_SUM = 2'd2,
        ST_TOO_MANY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_CHECK,
        S_DIV,
        S_DONE
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic capture;
        logic accum;
        logic div_load;
        logic div_step;
        logic emit_special;
        logic emit_div;
    } wsf_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic in_valid;
        logic last;
        logic special;
        logic div_last;
        logic out_free;
    } wsf_sts_t;

endpackage

### hw/rtl/wsf_if.sv
interface wsf_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sensor_value;
    logic        [15:0] score;
    logic               discard;
    logic               last_sensor;

    modport source (
        output valid, sensor_value, score, discard, last_sensor,
        input  ready
    );
    modport sink (
        input  valid, sensor_value, score, discard, last_sensor,
        output ready
    );
endinterface

interface wsf_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] fused_value;
    logic        [1:0]  status;

    modport source (
        output valid, fused_value, status,
        input  ready
    );
    modport sink (
        input  valid, fused_value, status,
        output ready
    );
endinterface

### hw/rtl/wsf_datapath.sv
module wsf_datapath #(
    parameter int MAX_SENSORS = wsf_pkg::DEF_MAX_SENSORS
) (
    input  logic              clk,
    input  logic              rst_n,
    wsf_in_if.sink            sample,
    wsf_out_if.source         result,
    input  wsf_pkg::wsf_cmd_t cmd,
    output wsf_pkg::wsf_sts_t sts
);
    import wsf_pkg::*;

    localparam int CW     = $clog2(MAX_SENSORS + 1);
    localparam int IW     = $clog2(MAX_SENSORS + 2);
    localparam int SUM_W  = SCORE_W + CW;
    localparam int WSUM_W = PROD_W + CW;
    localparam logic [IW-1:0] MAX_CNT = IW'(MAX_SENSORS);

    // Captured item
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic        [SCORE_W-1:0] score_cap_reg;
    logic                      discard_reg;
    logic                      last_reg, last_next;

    // Set accumulators
    logic        [IW-1:0]      item_cnt_reg, item_cnt_next;
    logic        [CW-1:0]      valid_cnt_reg, valid_cnt_next;
    logic        [SUM_W-1:0]   score_sum_reg, score_sum_next;
    logic signed [WSUM_W-1:0]  wsum_reg, wsum_next;

    // Divider
    logic        [WSUM_W-1:0]  wmag;
    logic        [SUM_W-1:0]   rem_reg, rem_next;
    logic        [QUO_W-1:0]   quo_reg, quo_next;
    logic        [DCNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic                      neg_reg, neg_next;
    logic        [SUM_W:0]     trial;
    logic                      trial_ge;
    logic        [QUO_W-1:0]   quo_signed;

    // Output register
    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] fused_reg, fused_next;
    logic        [STATUS_W-1:0] status_reg, status_next;

    status_t                   code;
    logic                      emit;
    logic                      out_free;

    assign emit     = cmd.emit_special || cmd.emit_div;
    assign out_free = !out_valid_reg || result.ready;

    // Input capture and product
    assign prod_next = cmd.capture
                     ? sample.sensor_value * $signed({1'b0, sample.score})
                     : prod_reg;
    assign last_next = cmd.capture ? sample.last_sensor : (emit ? 1'b0 : last_reg);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd.capture)
        begin
            score_cap_reg <= sample.score;
            discard_reg   <= sample.discard;
        end
    end

    // Accumulate one reading, clear on result
    always_comb
    begin
        item_cnt_next  = item_cnt_reg;
        valid_cnt_next = valid_cnt_reg;
        score_sum_next = score_sum_reg;
        wsum_next      = wsum_reg;
        if (emit)
        begin
            item_cnt_next  = '0;
            valid_cnt_next = '0;
            score_sum_next = '0;
            wsum_next      = '0;
        end
        else if (cmd.accum)
        begin
            if (item_cnt_reg <= MAX_CNT)
                item_cnt_next = item_cnt_reg + IW'(1);
            if (item_cnt_reg < MAX_CNT && !discard_reg)
            begin
                valid_cnt_next = valid_cnt_reg + CW'(1);
                score_sum_next = score_sum_reg + SUM_W'(score_cap_reg);
                wsum_next      = wsum_reg + WSUM_W'(prod_reg);
            end
        end
    end

    // Special-case status, in order of precedence
    always_comb
    begin
        priority if (item_cnt_reg > MAX_CNT)
            code = ST_TOO_MANY;
        else if (valid_cnt_reg == '0)
            code = ST_NO_VALID;
        else if (score_sum_reg == '0)
            code = ST_ZERO_SUM;
        else
            code = ST_OK;
    end

    // Restoring divider on magnitudes, one quotient bit per cycle
    assign wmag     = wsum_reg[WSUM_W-1] ? WSUM_W'(-wsum_reg) : WSUM_W'(wsum_reg);
    assign trial    = {rem_reg, quo_reg[QUO_W-1]};
    assign trial_ge = trial >= {1'b0, score_sum_reg};

    always_comb
    begin
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        div_cnt_next = div_cnt_reg;
        neg_next     = neg_reg;
        if (cmd.div_load)
        begin
            rem_next     = SUM_W'(wmag >> QUO_W);
            quo_next     = wmag[QUO_W-1:0];
            div_cnt_next = '0;
            neg_next     = wsum_reg[WSUM_W-1];
        end
        else if (cmd.div_step)
        begin
            rem_next     = trial_ge ? SUM_W'(trial - {1'b0, score_sum_reg})
                                    : SUM_W'(trial);
            quo_next     = {quo_reg[QUO_W-2:0], trial_ge};
            div_cnt_next = div_cnt_reg + DCNT_W'(1);
        end
    end

    assign quo_signed = neg_reg ? QUO_W'(-quo_reg) : quo_reg;

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        fused_next     = fused_reg;
        status_next    = status_reg;
        if (cmd.emit_special)
        begin
            out_valid_next = 1'b1;
            fused_next     = '0;
            status_next    = code;
        end
        else if (cmd.emit_div)
        begin
            out_valid_next = 1'b1;
            fused_next     = $signed(quo_signed[VALUE_W-1:0]);
            status_next    = ST_OK;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        div_cnt_reg <= div_cnt_next;
        neg_reg     <= neg_next;
        fused_reg   <= fused_next;
        status_reg  <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= 1'b0;
            item_cnt_reg  <= '0;
            valid_cnt_reg <= '0;
            score_sum_reg <= '0;
            wsum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            last_reg      <= last_next;
            item_cnt_reg  <= item_cnt_next;
            valid_cnt_reg <= valid_cnt_next;
            score_sum_reg <= score_sum_next;
            wsum_reg      <= wsum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Ports and status
    assign sample.ready       = cmd.in_ready;
    assign result.valid       = out_valid_reg;
    assign result.fused_value = fused_reg;
    assign result.status      = status_reg;

    assign sts.in_valid = sample.valid;
    assign sts.last     = last_reg;
    assign sts.special  = (code != ST_OK);
    assign sts.div_last = (div_cnt_reg == DCNT_W'(QUO_W - 1));
    assign sts.out_free = out_free;

    // Never overwrite a result that is still waiting
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result emitted over a pending transfer");

    // Set state is cleared after every result
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (item_cnt_reg == '0 && valid_cnt_reg == '0 && score_sum_reg == '0))
        else $error("set not cleared after result");

    // Division only starts on a regular set
    a_div_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_load |-> (item_cnt_reg <= MAX_CNT && valid_cnt_reg != '0
                          && score_sum_reg != '0))
        else $error("division started on a special set");

    // Weighted mean stays within the signed 16-bit range
    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_div |-> (neg_reg ? (quo_reg <= QUO_LIM) : (quo_reg < QUO_LIM)))
        else $error("quotient out of range");

endmodule

### hw/rtl/wsf_ctrl.sv
module wsf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  wsf_pkg::wsf_sts_t sts,
    output wsf_pkg::wsf_cmd_t cmd
);
    import wsf_pkg::*;

    state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (sts.in_valid)
                    state_next = S_ACC;
            S_ACC:
                state_next = sts.last ? S_CHECK : S_IDLE;
            S_CHECK:
                if (!sts.special)
                    state_next = S_DIV;
                else if (sts.out_free)
                    state_next = S_IDLE;
            S_DIV:
                if (sts.div_last)
                    state_next = S_DONE;
            S_DONE:
                if (sts.out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.capture  = sts.in_valid;
            end
            S_ACC:
                cmd.accum = 1'b1;
            S_CHECK:
            begin
                cmd.div_load     = !sts.special;
                cmd.emit_special = sts.special && sts.out_free;
            end
            S_DIV:
                cmd.div_step = 1'b1;
            S_DONE:
                cmd.emit_div = sts.out_free;
            default:
                cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Only one input transfer in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == S_ACC && !cmd.in_ready))
        else $error("input taken while item in flight");

    // A last item always reaches the result decision
    a_last_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC && sts.last) |=> state_reg == S_CHECK)
        else $error("last item skipped result decision");

    // Division runs to completion before emitting
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && !sts.div_last) |=> state_reg == S_DIV)
        else $error("division left early");

endmodule

### hw/rtl/weighted_sensor_fusion.sv
// A reading that is not last is captured (S_IDLE) and then accumulated (S_ACC).
// A last reading then reaches the result decision (S_CHECK), which emits a special
// status or loads the 17-step serial divider (S_DIV), whose result goes out from S_DONE.
// The next reading is taken only once the previous one is accumulated; after a last
// reading, only once its result is emitted, which waits while an earlier result is pending.
// Reset (rst_n low, asynchronous) clears the set sums and counts and the output valid.
module weighted_sensor_fusion #(
    parameter int MAX_SENSORS = wsf_pkg::DEF_MAX_SENSORS
) (
    input  logic      clk,
    input  logic      rst_n,
    wsf_in_if.sink    sample,
    wsf_out_if.source result
);
    import wsf_pkg::*;

    wsf_cmd_t cmd;
    wsf_sts_t sts;

    wsf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    wsf_datapath #(
        .MAX_SENSORS (MAX_SENSORS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .result (result),
        .cmd    (cmd),
        .sts    (sts)
    );

endmodule

### tb/weighted_sensor_fusion_tb.sv
`timescale 1ns / 1ps

module weighted_sensor_fusion_tb;
    import wsf_pkg::*;

    localparam int SET_MAX     = DEF_MAX_SENSORS;
    localparam int RAND_ITEMS  = 1650;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;
    localparam int IDLE_PCT    = 32;
    localparam int DIR_ROWS    = 20;

    // One stimulus row: a reading plus an optional hand-computed result
    typedef struct packed {
        logic signed [15:0] value;
        logic        [15:0] score;
        logic               discard;
        logic               last;
        logic               typed;
        logic signed [15:0] exp_value;
        status_t            exp_status;
    } reading_row_t;

    typedef struct packed {
        logic signed [15:0] value;
        status_t            status;
    } fused_t;

    logic clk;
    logic rst_n;

    wsf_in_if  sensor_in ();
    wsf_out_if fused_out ();

    weighted_sensor_fusion u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sensor_in),
        .result (fused_out)
    );

    // Running sums of the set being fused
    logic signed [63:0] score_sum;
    logic signed [63:0] weighted_sum;
    int                 set_len;
    int                 valid_len;
    fused_t             fuse_pred;

    fused_t fused_due [$];
    int     errors;
    int     cycles;
    int     readings;
    int     sets_done;
    int     status_hits [4];
    bit     calm;
    bit     typed_on;
    fused_t typed_res;

    // Directed sweep: extremes, every status but too-many, precedence and truncation
    reading_row_t sweep_rows [0:DIR_ROWS-1] = '{
        // lone discarded reading
        '{16'sd100,    16'd256,   1'b1, 1'b1, 1'b1, 16'sd0,      ST_NO_VALID},
        // full-scale positive and negative values
        '{16'sd32767,  16'd65535, 1'b0, 1'b1, 1'b1, 16'sd32767,  ST_OK},
        '{-16'sd32768, 16'd65535, 1'b0, 1'b1, 1'b1, -16'sd32768, ST_OK},
        // zero score sum
        '{16'sd1234,   16'd0,     1'b0, 1'b1, 1'b1, 16'sd0,      ST_ZERO_SUM},
        '{-16'sd32768, 16'd0,     1'b0, 1'b0, 1'b0, 16'sd0,      ST_OK},
        '{16'sd32767,  16'd0,     1'b0, 1'b1, 1'b1, 16'sd0,      ST_ZERO_SUM},
        // heavy positive against a tiny negative weight
        '{16'sd32767,  16'd65535, 1'b0, 1'b0, 1'b0, 16'sd0,      ST_OK},
        '{-16'sd32768, 16'd1,     1'b0, 1'b1, 1'b0, 16'sd0,      ST_OK},
        // small negative mean truncates toward zero
        '{-16'sd1,     16'd3,     1'b0, 1'b0, 1'b0, 16'sd0,      ST_OK},
        '{16'sd0,      16'd2,     1'b0, 1'b1, 1'b0, 16'sd0,      ST_OK},
        // discarded reading must not count
        '{-16'sd256,   16'd65535, 1'b1, 1'b0, 1'b0, 16'sd0,      ST_OK},
        '{16'sd512,    16'd1,     1'b0, 1'b1, 1'b1, 16'sd512,    ST_OK},
        // all discarded, last one too
        '{16'sd0,      16'd0,     1'b1, 1'b0, 1'b0, 16'sd0,      ST_OK},
        '{-16'sd1,     16'd65535, 1'b1, 1'b1, 1'b1, 16'sd0,      ST_NO_VALID},
        // mixed set
        '{-16'sd300,   16'd128,   1'b0, 1'b0, 1'b0, 16'sd0,      ST_OK},
        '{16'sd700,    16'd384,   1'b0, 1'b0, 1'b0, 16'sd0,      ST_OK},
        '{-16'sd5,     16'd0,     1'b1, 1'b0, 1'b0, 16'sd0,      ST_OK},
        '{16'sd1,      16'd1,     1'b0, 1'b1, 1'b0, 16'sd0,      ST_OK},
        // discarded then accepted with zero score
        '{16'sd55,     16'd0,     1'b1, 1'b0, 1'b0, 16'sd0,      ST_OK},
        '{-16'sd55,    16'd0,     1'b0, 1'b1, 1'b1, 16'sd0,      ST_ZERO_SUM}
    };

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Fold one reading into the set; returns 1 when a result is due
    function automatic bit fuse_reading(input logic signed [15:0] v, input logic [15:0] s,
                                        input logic disc, input logic last);
        logic signed [63:0] q;
        if (set_len <= SET_MAX)
            set_len++;
        if (set_len <= SET_MAX && !disc)
        begin
            score_sum    = score_sum + $signed({1'b0, s});
            weighted_sum = weighted_sum + v * $signed({1'b0, s});
            valid_len++;
        end
        if (!last)
            return 1'b0;

        fuse_pred.value = '0;
        if (set_len > SET_MAX)
            fuse_pred.status = ST_TOO_MANY;
        else if (valid_len == 0)
            fuse_pred.status = ST_NO_VALID;
        else if (score_sum == 0)
            fuse_pred.status = ST_ZERO_SUM;
        else
        begin
            fuse_pred.status = ST_OK;
            q = weighted_sum / score_sum;
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
            fuse_pred.value = q[15:0];
        end
        score_sum    = '0;
        weighted_sum = '0;
        set_len      = 0;
        valid_len    = 0;
        return 1'b1;
    endfunction

    // Present one reading and hold it until the transfer completes
    task automatic send_reading(input reading_row_t r);
        bit fire;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            sensor_in.valid <= 1'b0;
            @(posedge clk);
        end
        sensor_in.valid        <= 1'b1;
        sensor_in.sensor_value <= r.value;
        sensor_in.score        <= r.score;
        sensor_in.discard      <= r.discard;
        sensor_in.last_sensor  <= r.last;
        typed_on               = r.typed;
        typed_res.value        = r.exp_value;
        typed_res.status       = r.exp_status;
        do
        begin
            @(negedge clk);
            fire = sensor_in.valid && sensor_in.ready;
            @(posedge clk);
        end
        while (!fire);
    endtask

    // Random result back-pressure
    always @(posedge clk)
        fused_out.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d results still due", cycles, fused_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Sample both channels mid-cycle, where every signal is settled
    always @(negedge clk)
    begin
        fused_t want;
        if (rst_n)
        begin
            if (sensor_in.valid && sensor_in.ready)
            begin
                readings++;
                if (fuse_reading(sensor_in.sensor_value, sensor_in.score,
                                 sensor_in.discard, sensor_in.last_sensor))
                    fused_due.push_back(typed_on ? typed_res : fuse_pred);
            end
            if (fused_out.valid && fused_out.ready)
            begin
                if (fused_due.size() == 0)
                begin
                    $error("unexpected result: fused_value %0d status %0d",
                           fused_out.fused_value, fused_out.status);
                    errors++;
                end
                else
                begin
                    want = fused_due.pop_front();
                    sets_done++;
                    status_hits[fused_out.status]++;
                    if (fused_out.fused_value !== want.value)
                    begin
                        $error("fused_value: expected %0d, got %0d",
                               want.value, fused_out.fused_value);
                        errors++;
                    end
                    if (fused_out.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, fused_out.status);
                        errors++;
                    end
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        reading_row_t r;
        int sent;
        int set_no;
        int len;
        int drop_pct;
        bit zero_scores;

        score_sum    = '0;
        weighted_sum = '0;
        set_len      = 0;
        valid_len    = 0;
        errors       = 0;
        cycles       = 0;
        readings     = 0;
        sets_done    = 0;
        status_hits  = '{default: 0};
        calm         = 1'b0;
        typed_on     = 1'b0;
        typed_res    = '0;

        rst_n                  <= 1'b0;
        sensor_in.valid        <= 1'b0;
        sensor_in.sensor_value <= '0;
        sensor_in.score        <= '0;
        sensor_in.discard      <= 1'b0;
        sensor_in.last_sensor  <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sweep
        for (int i = 0; i < DIR_ROWS; i++)
            send_reading(sweep_rows[i]);

        // Random sets; first two sit right at and just over the limit
        sent   = 0;
        set_no = 0;
        while (sent < RAND_ITEMS)
        begin
            if (set_no == 0)
                len = SET_MAX;
            else if (set_no == 1)
                len = SET_MAX + 1;
            else if ($urandom_range(99) < 8)
                len = $urandom_range(SET_MAX + 3, SET_MAX - 2);
            else
                len = $urandom_range(8, 1);
            case ($urandom_range(3))
                0: drop_pct = 0;
                1: drop_pct = 20;
                2: drop_pct = 50;
                default: drop_pct = ($urandom_range(3) == 0) ? 100 : 10;
            endcase
            zero_scores = ($urandom_range(11) == 0);

            for (int k = 0; k < len; k++)
            begin
                calm = (sent >= 700 && sent < 1000);
                r = '0;
                case ($urandom_range(7))
                    0: r.value = -16'sd32768;
                    1: r.value = 16'sd32767;
                    2: r.value = ($urandom_range(1) != 0) ? 16'sd0 : -16'sd1;
                    default: r.value = 16'($urandom_range(65535));
                endcase
                if (zero_scores)
                    r.score = '0;
                else
                    case ($urandom_range(7))
                        0: r.score = 16'hFFFF;
                        1: r.score = '0;
                        2: r.score = 16'($urandom_range(255));
                        default: r.score = 16'($urandom_range(65535));
                    endcase
                r.discard = ($urandom_range(99) < drop_pct);
                r.last    = (k == len - 1);
                send_reading(r);
                sent++;
            end
            set_no++;
        end
        sensor_in.valid <= 1'b0;
        calm = 1'b0;

        // Drain
        while (fused_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Fused %0d readings into %0d sets over %0d cycles.",
                 readings, sets_done, cycles);
        $display("Status counts: ok %0d, no valid %0d, zero sum %0d, too many %0d.",
                 status_hits[ST_OK], status_hits[ST_NO_VALID],
                 status_hits[ST_ZERO_SUM], status_hits[ST_TOO_MANY]);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
